// File: rtl/core/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// Used by pli_ctrl, pli_datapath and the top level piecewise_linear_interp.
package pli_pkg;

    localparam int DATA_W      = 32;
    localparam int INDEX_W     = 6;
    localparam int COUNT_W     = 7;
    localparam int TABLE_DEPTH = 64;
    localparam int DIV_STEPS   = 32;
    localparam int STEP_W      = 5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_IDX,
        ADDR_IDX_NEXT
    } pli_addr_sel_t;

    typedef enum logic {
        RES_CLAMP,
        RES_INTERP
    } pli_res_sel_t;

    typedef struct packed {
        logic          wr_en;
        logic          load_query;
        logic          cap_first;
        logic          cap_cur;
        logic          advance;
        logic          mul_load;
        logic          div_step;
        logic          out_load;
        pli_addr_sel_t addr_sel;
        pli_res_sel_t  res_sel;
    } pli_cmd_t;

    typedef struct packed {
        logic q_le_rd;
        logic q_ge_rd;
        logic at_last;
        logic out_free;
    } pli_status_t;

endpackage

// File: rtl/core/pli_datapath.sv
// Datapath of the interpolator: breakpoint memories, search registers,
// multiplier, restoring divider and output register. Depends on pli_pkg.
module pli_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pli_pkg::pli_cmd_t                cmd_bus,
    output pli_pkg::pli_status_t             status,
    input  logic                             cfg_we,
    input  logic [pli_pkg::COUNT_W-1:0]      point_count,
    input  logic [pli_pkg::INDEX_W-1:0]      point_index,
    input  logic signed [pli_pkg::DATA_W-1:0] point_x,
    input  logic signed [pli_pkg::DATA_W-1:0] point_y,
    input  logic signed [pli_pkg::DATA_W-1:0] query_x,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [pli_pkg::DATA_W-1:0] y_value
);
    import pli_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [DATA_W-1:0] mem_x [TABLE_DEPTH];
    logic [DATA_W-1:0] mem_y [TABLE_DEPTH];

    logic [DATA_W-1:0] rd_x_reg, rd_y_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [31:0]       idx_ext;
    logic              wr_in_range;

    logic [AW-1:0]     last_reg, last_next;
    logic [31:0]       cnt_ext;

    logic [AW-1:0]     i_reg;
    logic signed [DATA_W-1:0] q_reg;
    logic signed [DATA_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;

    logic [DATA_W:0]   dx_full, den_full, dy_full, dy_mag_full;
    logic [DATA_W-1:0] dy_mag;
    logic [2*DATA_W-1:0] product;

    logic [DATA_W-1:0] den_reg, rem_reg, dq_reg;
    logic              neg_reg;
    logic [DATA_W:0]   trial;
    logic              trial_ge;

    logic [DATA_W-1:0] interp_val;
    logic [DATA_W-1:0] result;
    logic              out_valid_reg;
    logic [DATA_W-1:0] y_value_reg;

    // Write address; indexes beyond the table are dropped.
    assign idx_ext     = 32'(point_index);
    assign wr_in_range = idx_ext < 32'(TABLE_DEPTH);
    assign wr_addr     = idx_ext[AW-1:0];

    always_comb
    begin
        case (cmd_bus.addr_sel)
            ADDR_ZERO:     rd_addr = '0;
            ADDR_LAST:     rd_addr = last_reg;
            ADDR_IDX:      rd_addr = i_reg;
            ADDR_IDX_NEXT: rd_addr = i_reg + AW'(1);
            default:       rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_bus.wr_en && wr_in_range)
        begin
            mem_x[wr_addr] <= point_x;
            mem_y[wr_addr] <= point_y;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    // The count register is kept as the index of the last entry in use.
    always_comb
    begin
        cnt_ext = 32'(point_count);
        if (cnt_ext == 32'd0)
            last_next = '0;
        else if (cnt_ext > 32'(TABLE_DEPTH))
            last_next = AW'(TABLE_DEPTH - 1);
        else
            last_next = AW'(cnt_ext - 32'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= '0;
        else if (cfg_we)
            last_reg <= last_next;
    end

    assign status.q_le_rd  = q_reg <= $signed(rd_x_reg);
    assign status.q_ge_rd  = q_reg >= $signed(rd_x_reg);
    assign status.at_last  = i_reg == last_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    // Both differences are positive and below 2^32 on the chosen interval.
    assign dx_full     = {q_reg[DATA_W-1], q_reg} - {x0_reg[DATA_W-1], x0_reg};
    assign den_full    = {x1_reg[DATA_W-1], x1_reg} - {x0_reg[DATA_W-1], x0_reg};
    assign dy_full     = {y1_reg[DATA_W-1], y1_reg} - {y0_reg[DATA_W-1], y0_reg};
    assign dy_mag_full = dy_full[DATA_W] ? (~dy_full + 1'b1) : dy_full;
    assign dy_mag      = dy_mag_full[DATA_W-1:0];
    assign product     = dx_full[DATA_W-1:0] * dy_mag;

    assign trial    = {rem_reg, dq_reg[DATA_W-1]};
    assign trial_ge = trial >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd_bus.load_query)
        begin
            q_reg <= query_x;
            i_reg <= AW'(1);
        end
        if (cmd_bus.cap_first)
        begin
            x0_reg <= rd_x_reg;
            y0_reg <= rd_y_reg;
        end
        if (cmd_bus.cap_first || cmd_bus.cap_cur)
        begin
            x1_reg <= rd_x_reg;
            y1_reg <= rd_y_reg;
        end
        if (cmd_bus.advance)
        begin
            x0_reg <= rd_x_reg;
            y0_reg <= rd_y_reg;
            i_reg  <= i_reg + AW'(1);
        end
        // The quotient fits 32 bits, so the upper product half starts below den.
        if (cmd_bus.mul_load)
        begin
            rem_reg <= product[2*DATA_W-1:DATA_W];
            dq_reg  <= product[DATA_W-1:0];
            den_reg <= den_full[DATA_W-1:0];
            neg_reg <= dy_full[DATA_W];
        end
        else if (cmd_bus.div_step)
        begin
            if (trial_ge)
                rem_reg <= DATA_W'(trial - {1'b0, den_reg});
            else
                rem_reg <= trial[DATA_W-1:0];
            dq_reg <= {dq_reg[DATA_W-2:0], trial_ge};
        end
    end

    assign interp_val = neg_reg ? (y0_reg - dq_reg) : (y0_reg + dq_reg);

    always_comb
    begin
        case (cmd_bus.res_sel)
            RES_CLAMP:  result = y1_reg;
            RES_INTERP: result = interp_val;
            default:    result = y1_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd_bus.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_bus.out_load)
            y_value_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign y_value   = y_value_reg;

endmodule

// File: rtl/core/pli_ctrl.sv
// Controller of the interpolator: sequences the clamp checks, the interval
// search, the multiply and the divide steps. Depends on pli_pkg.
module pli_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  pli_pkg::pli_status_t status,
    output pli_pkg::pli_cmd_t    cmd_bus
);
    import pli_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t       state_reg, state_next;
    pli_res_sel_t res_sel_reg, res_sel_next;
    logic [STEP_W-1:0] step_reg, step_next;

    assign in_stall = state_reg != ST_IDLE;

    always_comb
    begin
        state_next   = state_reg;
        res_sel_next = res_sel_reg;
        step_next    = step_reg;

        cmd_bus            = '0;
        cmd_bus.addr_sel   = ADDR_ZERO;
        cmd_bus.res_sel    = res_sel_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Entry zero is read here so that it is ready in the first step.
                cmd_bus.addr_sel = ADDR_ZERO;
                if (in_valid && cmd == CMD_WRITE)
                    cmd_bus.wr_en = 1'b1;
                if (in_valid && cmd == CMD_QUERY)
                begin
                    cmd_bus.load_query = 1'b1;
                    state_next         = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                cmd_bus.cap_first = 1'b1;
                cmd_bus.addr_sel  = ADDR_LAST;
                if (status.q_le_rd)
                begin
                    res_sel_next = RES_CLAMP;
                    state_next   = ST_DONE;
                end
                else
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                cmd_bus.cap_cur  = 1'b1;
                cmd_bus.addr_sel = ADDR_IDX;
                if (status.q_ge_rd)
                begin
                    res_sel_next = RES_CLAMP;
                    state_next   = ST_DONE;
                end
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd_bus.cap_cur = 1'b1;
                if (status.at_last || status.q_le_rd)
                    state_next = ST_MUL;
                else
                begin
                    cmd_bus.advance  = 1'b1;
                    cmd_bus.addr_sel = ADDR_IDX_NEXT;
                end
            end
            ST_MUL:
            begin
                cmd_bus.mul_load = 1'b1;
                res_sel_next     = RES_INTERP;
                step_next        = '0;
                state_next       = ST_DIV;
            end
            ST_DIV:
            begin
                cmd_bus.div_step = 1'b1;
                step_next        = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd_bus.out_load = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            res_sel_reg <= RES_CLAMP;
            step_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
            step_reg    <= step_next;
        end
    end

endmodule

// File: rtl/core/piecewise_linear_interp.sv
// Clamped piecewise linear interpolation over a breakpoint table, Q16.16.
// A write item is taken in the idle state without stalling the input. A query
// clamps at the first entry, clamps at the last, or interpolates: one memory
// read per search step, then 32 divide steps. The next item is accepted once
// the result sits in the output register. Reset clears control state and sets
// the count to one.
module piecewise_linear_interp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [pli_pkg::INDEX_W-1:0]       point_index,
    input  logic signed [pli_pkg::DATA_W-1:0] point_x,
    input  logic signed [pli_pkg::DATA_W-1:0] point_y,
    input  logic signed [pli_pkg::DATA_W-1:0] query_x,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [pli_pkg::DATA_W-1:0] y_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pli_pkg::COUNT_W-1:0]       point_count
);
    import pli_pkg::*;

    pli_cmd_t    cmd_bus;
    pli_status_t status;

    assign cfg_ready = 1'b1;

    pli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status),
        .cmd_bus  (cmd_bus)
    );

    pli_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_bus     (cmd_bus),
        .status      (status),
        .cfg_we      (cfg_valid && cfg_ready),
        .point_count (point_count),
        .point_index (point_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .query_x     (query_x),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .y_value     (y_value)
    );

endmodule
